FILE: sv/swc_pkg.sv
// Shared types, constants and lookup tables for the square-wave channel.
package swc_pkg;

   localparam int unsigned CMD_W = 3;
   localparam int unsigned IDX_W = 2;
   localparam int unsigned DATA_W = 8;
   localparam int unsigned SAMPLE_W = 4;
   localparam int unsigned PERIOD_W = 11;
   localparam int unsigned TARGET_W = 12;

   localparam logic ONES_COMPLEMENT_NEGATE = 1'b1;
   localparam logic [TARGET_W-1:0] PERIOD_MAX = 12'h7FF;
   localparam logic [TARGET_W-1:0] TARGET_MAX = 12'hFFF;
   localparam logic [PERIOD_W-1:0] PERIOD_MIN = 11'd8;
   localparam logic [3:0] DECAY_FULL = 4'd15;

   typedef enum logic [CMD_W-1:0] {
      CMD_REG_WRITE    = 3'd0,
      CMD_ENABLE_WRITE = 3'd1,
      CMD_TIMER_TICK   = 3'd2,
      CMD_QUARTER      = 3'd3,
      CMD_HALF         = 3'd4
   } cmd_type;

   typedef enum logic [IDX_W-1:0] {
      REG_DUTY_ENV    = 2'd0,
      REG_SWEEP       = 2'd1,
      REG_PERIOD_LOW  = 2'd2,
      REG_PERIOD_HIGH = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [IDX_W-1:0]  reg_index;
      logic [DATA_W-1:0] write_data;
   } item_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                length_active;
   } result_type;

   function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] step);
      logic [7:0] row;
      case (sel)
         2'd0:    row = 8'b0000_0010;
         2'd1:    row = 8'b0000_0110;
         2'd2:    row = 8'b0001_1110;
         default: row = 8'b1111_1001;
      endcase
      return row[step];
   endfunction

   function automatic logic [7:0] length_lookup(input logic [4:0] index);
      logic [7:0] value;
      case (index)
         5'd0:    value = 8'd10;
         5'd1:    value = 8'd254;
         5'd2:    value = 8'd20;
         5'd3:    value = 8'd2;
         5'd4:    value = 8'd40;
         5'd5:    value = 8'd4;
         5'd6:    value = 8'd80;
         5'd7:    value = 8'd6;
         5'd8:    value = 8'd160;
         5'd9:    value = 8'd8;
         5'd10:   value = 8'd60;
         5'd11:   value = 8'd10;
         5'd12:   value = 8'd14;
         5'd13:   value = 8'd12;
         5'd14:   value = 8'd26;
         5'd15:   value = 8'd14;
         5'd16:   value = 8'd12;
         5'd17:   value = 8'd16;
         5'd18:   value = 8'd24;
         5'd19:   value = 8'd18;
         5'd20:   value = 8'd48;
         5'd21:   value = 8'd20;
         5'd22:   value = 8'd96;
         5'd23:   value = 8'd22;
         5'd24:   value = 8'd192;
         5'd25:   value = 8'd24;
         5'd26:   value = 8'd72;
         5'd27:   value = 8'd26;
         5'd28:   value = 8'd16;
         5'd29:   value = 8'd28;
         5'd30:   value = 8'd32;
         default: value = 8'd30;
      endcase
      return value;
   endfunction

endpackage

FILE: sv/square_wave_channel_with_sweep.sv
// Top level of the square-wave channel: input register, channel core and result register.
//
//   channel   ports                                        direction
//   request   req_valid req_stall req_cmd req_reg_index    in (stall out)
//             req_write_data
//   response  rsp_valid rsp_stall rsp_sample               out (stall in)
//             rsp_length_active
//
// One transaction is accepted per cycle while req_stall is low; the single state-update stage between the
// input register and the result register sets that rate.
// A request passes the input register, and its result is then registered in the result register with rsp_valid.
// Reset is synchronous and clears the channel state and both valid flags.
// A stalled result holds the core; the input register then fills and raises req_stall.
module square_wave_channel_with_sweep import swc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [IDX_W-1:0]    req_reg_index,
   input  logic [DATA_W-1:0]   req_write_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SAMPLE_W-1:0] rsp_sample,
   output logic                rsp_length_active
);

   logic       in_vld_ff, in_vld_in;
   item_type   in_item_ff;
   logic       out_vld_ff, out_vld_in;
   result_type out_res_ff;
   result_type core_res;
   logic       core_go;
   logic       req_take;

   assign core_go = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !core_go;
   assign req_take = req_valid && !req_stall;

   always_comb begin
      in_vld_in = req_take || (in_vld_ff && !core_go);
      out_vld_in = core_go || (out_vld_ff && rsp_stall);
   end

   swc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .go     (core_go),
      .item   (in_item_ff),
      .result (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= '{cmd: req_cmd, reg_index: req_reg_index, write_data: req_write_data};
      end
      if (core_go) begin
         out_res_ff <= core_res;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_sample = out_res_ff.sample;
   assign rsp_length_active = out_res_ff.length_active;

   a_sample_needs_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_sample != '0)) |-> rsp_length_active)
      else $error("nonzero sample while length counter is zero");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_core_fills_result: assert property (@(posedge clock) disable iff (reset)
      core_go |=> rsp_valid)
      else $error("processed transaction produced no result");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_vld_ff && out_vld_ff && rsp_stall))
      else $error("request stalled without a blocked pipeline");

endmodule

FILE: sv/swc_core.sv
// Channel state registers and the per-transaction state update and sample logic.
module swc_core import swc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       go,
   input  item_type   item,
   output result_type result
);

   logic [1:0]          duty_select_ff, duty_select_in;
   logic                halt_loop_ff, halt_loop_in;
   logic                constant_volume_ff, constant_volume_in;
   logic [3:0]          volume_or_rate_ff, volume_or_rate_in;
   logic [7:0]          sweep_settings_ff, sweep_settings_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [TARGET_W-1:0] target_period_ff, target_period_in;
   logic [PERIOD_W-1:0] timer_count_ff, timer_count_in;
   logic [2:0]          duty_step_ff, duty_step_in;
   logic [7:0]          length_count_ff, length_count_in;
   logic                length_enable_ff, length_enable_in;
   logic                envelope_start_ff, envelope_start_in;
   logic [3:0]          envelope_divider_ff, envelope_divider_in;
   logic [3:0]          envelope_decay_ff, envelope_decay_in;
   logic [2:0]          sweep_divider_ff, sweep_divider_in;
   logic                sweep_reload_ff, sweep_reload_in;
   logic                sweep_mute_ff, sweep_mute_in;

   logic [PERIOD_W-1:0] period_high_wr;
   logic [TARGET_W-1:0] sweep_delta;
   logic [TARGET_W:0]   sweep_sub;
   logic [TARGET_W:0]   sweep_sum;
   logic [TARGET_W-1:0] sweep_next;
   logic                sweep_go;
   logic [3:0]          volume;
   logic                wave_bit;

   always_comb begin
      sweep_delta = target_period_ff >> sweep_settings_ff[2:0];
      sweep_sub = {1'b0, sweep_delta} + {{TARGET_W{1'b0}}, ONES_COMPLEMENT_NEGATE};
      sweep_sum = {1'b0, target_period_ff} + {1'b0, sweep_delta};
      if (sweep_settings_ff[3]) begin
         if (sweep_sub > {1'b0, target_period_ff}) begin
            sweep_next = '0;
         end else begin
            sweep_next = target_period_ff - sweep_sub[TARGET_W-1:0];
         end
      end else if (sweep_sum[TARGET_W]) begin
         sweep_next = TARGET_MAX;
      end else begin
         sweep_next = sweep_sum[TARGET_W-1:0];
      end
      sweep_go = sweep_settings_ff[7] && (sweep_divider_ff == 3'd0) && !sweep_mute_ff
                 && (sweep_settings_ff[2:0] != 3'd0);
      period_high_wr = {item.write_data[2:0], period_ff[7:0]};
   end

   always_comb begin
      duty_select_in = duty_select_ff;
      halt_loop_in = halt_loop_ff;
      constant_volume_in = constant_volume_ff;
      volume_or_rate_in = volume_or_rate_ff;
      sweep_settings_in = sweep_settings_ff;
      period_in = period_ff;
      target_period_in = target_period_ff;
      timer_count_in = timer_count_ff;
      duty_step_in = duty_step_ff;
      length_count_in = length_count_ff;
      length_enable_in = length_enable_ff;
      envelope_start_in = envelope_start_ff;
      envelope_divider_in = envelope_divider_ff;
      envelope_decay_in = envelope_decay_ff;
      sweep_divider_in = sweep_divider_ff;
      sweep_reload_in = sweep_reload_ff;
      sweep_mute_in = sweep_mute_ff;

      if (go) begin
         case (cmd_type'(item.cmd))
            CMD_REG_WRITE: begin
               case (reg_index_type'(item.reg_index))
                  REG_DUTY_ENV: begin
                     duty_select_in = item.write_data[7:6];
                     halt_loop_in = item.write_data[5];
                     constant_volume_in = item.write_data[4];
                     volume_or_rate_in = item.write_data[3:0];
                  end
                  REG_SWEEP: begin
                     sweep_settings_in = item.write_data;
                     sweep_reload_in = 1'b1;
                  end
                  REG_PERIOD_LOW: begin
                     period_in = {period_ff[PERIOD_W-1:8], item.write_data};
                  end
                  REG_PERIOD_HIGH: begin
                     period_in = period_high_wr;
                     if (length_enable_ff) begin
                        length_count_in = length_lookup(item.write_data[7:3]);
                     end
                     timer_count_in = period_high_wr;
                     target_period_in = {1'b0, period_high_wr};
                     duty_step_in = 3'd0;
                     envelope_start_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
            CMD_ENABLE_WRITE: begin
               length_enable_in = item.write_data[0];
               if (!item.write_data[0]) begin
                  length_count_in = 8'd0;
               end
            end
            CMD_TIMER_TICK: begin
               if (timer_count_ff != '0) begin
                  timer_count_in = timer_count_ff - 1'b1;
               end else begin
                  timer_count_in = period_ff;
                  duty_step_in = duty_step_ff + 3'd1;
               end
            end
            CMD_QUARTER, CMD_HALF: begin
               if (envelope_start_ff) begin
                  envelope_start_in = 1'b0;
                  envelope_decay_in = DECAY_FULL;
                  envelope_divider_in = volume_or_rate_ff;
               end else if (envelope_divider_ff != 4'd0) begin
                  envelope_divider_in = envelope_divider_ff - 4'd1;
               end else begin
                  envelope_divider_in = volume_or_rate_ff;
                  if (envelope_decay_ff != 4'd0) begin
                     envelope_decay_in = envelope_decay_ff - 4'd1;
                  end else if (halt_loop_ff) begin
                     envelope_decay_in = DECAY_FULL;
                  end
               end
               if (item.cmd == CMD_HALF) begin
                  if (length_count_ff != 8'd0) begin
                     if (!length_enable_ff) begin
                        length_count_in = 8'd0;
                     end else if (!halt_loop_ff) begin
                        length_count_in = length_count_ff - 8'd1;
                     end
                  end
                  if (sweep_go) begin
                     target_period_in = sweep_next;
                     if (sweep_next <= PERIOD_MAX) begin
                        period_in = sweep_next[PERIOD_W-1:0];
                     end
                  end
                  if ((sweep_divider_ff == 3'd0) || sweep_reload_ff) begin
                     sweep_divider_in = sweep_settings_ff[6:4];
                     sweep_reload_in = 1'b0;
                  end else begin
                     sweep_divider_in = sweep_divider_ff - 3'd1;
                  end
                  sweep_mute_in = (target_period_in > PERIOD_MAX) || (period_in < PERIOD_MIN);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      volume = constant_volume_in ? volume_or_rate_in : envelope_decay_in;
      wave_bit = duty_bit(duty_select_in, duty_step_in);
      result.length_active = (length_count_in != 8'd0);
      result.sample = (result.length_active && !sweep_mute_in && wave_bit) ? volume : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_select_ff <= '0;
         halt_loop_ff <= 1'b0;
         constant_volume_ff <= 1'b0;
         volume_or_rate_ff <= '0;
         sweep_settings_ff <= '0;
         period_ff <= '0;
         target_period_ff <= '0;
         timer_count_ff <= '0;
         duty_step_ff <= '0;
         length_count_ff <= '0;
         length_enable_ff <= 1'b0;
         envelope_start_ff <= 1'b0;
         envelope_divider_ff <= '0;
         envelope_decay_ff <= '0;
         sweep_divider_ff <= '0;
         sweep_reload_ff <= 1'b0;
         sweep_mute_ff <= 1'b0;
      end else begin
         duty_select_ff <= duty_select_in;
         halt_loop_ff <= halt_loop_in;
         constant_volume_ff <= constant_volume_in;
         volume_or_rate_ff <= volume_or_rate_in;
         sweep_settings_ff <= sweep_settings_in;
         period_ff <= period_in;
         target_period_ff <= target_period_in;
         timer_count_ff <= timer_count_in;
         duty_step_ff <= duty_step_in;
         length_count_ff <= length_count_in;
         length_enable_ff <= length_enable_in;
         envelope_start_ff <= envelope_start_in;
         envelope_divider_ff <= envelope_divider_in;
         envelope_decay_ff <= envelope_decay_in;
         sweep_divider_ff <= sweep_divider_in;
         sweep_reload_ff <= sweep_reload_in;
         sweep_mute_ff <= sweep_mute_in;
      end
   end

endmodule
